/* sv/cu_pkg.sv */
package cu_pkg;

  localparam int MAX_ITEMS_DEF = 26;
  localparam int RANK_W        = 24;
  localparam int COUNT_W       = 5;
  localparam int COLS          = 1 << COUNT_W;
  localparam int BINOM_W       = RANK_W + 1;
  // Binomials at or above this value all compare the same against a rank.
  localparam logic [BINOM_W-1:0] BINOM_SAT = BINOM_W'(1) << RANK_W;

  typedef struct packed {
    logic [RANK_W-1:0]  rank_index;
    logic [COUNT_W-1:0] total_items;
    logic [COUNT_W-1:0] chosen_count;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] element;
    logic               last;
    logic               invalid;
  } rsp_t;

  // One binomial lookup: C(row, col)
  typedef struct packed {
    logic [COUNT_W-1:0] row;
    logic [COUNT_W-1:0] col;
  } lookup_t;

endpackage

/* sv/combination_unranker_top.sv */
// Channel  | Signals                          | Beat
// ---------+----------------------------------+--------------------------------------
// request  | req_valid, req_stall, req_data   | rank_index, total_items, chosen_count
// response | rsp_valid, rsp_stall, rsp_data   | element, last, invalid
//
// After reset a sweep builds Pascal's triangle in the binomial RAM, one entry a cycle;
// req_stall stays high until the sweep ends and the walker enters S_IDLE.
// A request passes setup (S_IDLE, S_CHECK), then the compare steps of the
// compare-subtract unit (at most n steps, one RAM read each), then k emit beats.
// A bad request gives one beat from S_BAD; k = 0 gives none and the unit stays in S_IDLE.
// The response register decouples the sides: a stalled beat holds, and the next request
// may be taken while the final beat still waits.
module combination_unranker_top #(
  parameter int MAX_ITEMS = cu_pkg::MAX_ITEMS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  cu_pkg::req_t  req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output cu_pkg::rsp_t  rsp_data
);

  localparam int ROWS = ((MAX_ITEMS < cu_pkg::COLS - 1) ? MAX_ITEMS : cu_pkg::COLS - 1) + 1;

  cu_pkg::lookup_t               lookup;
  logic [cu_pkg::BINOM_W-1:0]    binom;
  logic                          table_ready;

  cu_binom_table #(
    .ROWS (ROWS)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .lookup (lookup),
    .binom  (binom),
    .ready  (table_ready)
  );

  cu_walker #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_walker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_data    (req_data),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp_data    (rsp_data),
    .table_ready (table_ready),
    .lookup      (lookup),
    .binom       (binom)
  );

endmodule

/* sv/cu_ram.sv */
module cu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/cu_binom_table.sv */
module cu_binom_table #(
  parameter int ROWS = cu_pkg::MAX_ITEMS_DEF + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cu_pkg::lookup_t              lookup,
  output logic [cu_pkg::BINOM_W-1:0]   binom,
  output logic                         ready
);

  localparam int DEPTH = ROWS * cu_pkg::COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FULL_W = 2 * cu_pkg::COUNT_W;

  logic                          filling;
  logic [cu_pkg::COUNT_W-1:0]    fr;
  logic [cu_pkg::COUNT_W-1:0]    fc;
  logic                          w_valid;
  logic [cu_pkg::COUNT_W-1:0]    w_row;
  logic [cu_pkg::COUNT_W-1:0]    w_col;
  logic [cu_pkg::BINOM_W-1:0]    held;
  logic [cu_pkg::BINOM_W-1:0]    rdata;
  logic [cu_pkg::BINOM_W-1:0]    wdata;
  logic [cu_pkg::BINOM_W:0]      sum;
  logic [cu_pkg::COUNT_W-1:0]    prev_row;
  logic [FULL_W-1:0]             raddr_full;
  logic [FULL_W-1:0]             waddr_full;

  assign prev_row   = (fr == '0) ? '0 : fr - cu_pkg::COUNT_W'(1);
  assign raddr_full = filling ? {prev_row, fc} : {lookup.row, lookup.col};
  assign waddr_full = {w_row, w_col};

  // Pascal step: C(r,c) = C(r-1,c-1) + C(r-1,c), saturated; C(r,0) = 1, C(0,c) = 0 for c > 0
  assign sum = {1'b0, held} + {1'b0, rdata};
  always_comb begin
    if (w_col == '0) begin
      wdata = cu_pkg::BINOM_W'(1);
    end else if (w_row == '0) begin
      wdata = '0;
    end else if (sum >= {1'b0, cu_pkg::BINOM_SAT}) begin
      wdata = cu_pkg::BINOM_SAT;
    end else begin
      wdata = sum[cu_pkg::BINOM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filling <= 1'b1;
      fr      <= '0;
      fc      <= '0;
      w_valid <= 1'b0;
    end else begin
      w_valid <= filling;
      if (filling) begin
        fc <= fc + cu_pkg::COUNT_W'(1);
        if (fc == cu_pkg::COUNT_W'(cu_pkg::COLS - 1)) begin
          if (fr == cu_pkg::COUNT_W'(ROWS - 1)) begin
            filling <= 1'b0;
          end else begin
            fr <= fr + cu_pkg::COUNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    w_row <= fr;
    w_col <= fc;
    held  <= rdata;
  end

  assign ready = !filling && !w_valid;
  assign binom = rdata;

  cu_ram #(
    .WIDTH (cu_pkg::BINOM_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (w_valid),
    .waddr (waddr_full[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr_full[AW-1:0]),
    .rdata (rdata)
  );

endmodule

/* sv/cu_walker.sv */
module cu_walker #(
  parameter int MAX_ITEMS = cu_pkg::MAX_ITEMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  cu_pkg::req_t                 req_data,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output cu_pkg::rsp_t                 rsp_data,
  input  logic                         table_ready,
  output cu_pkg::lookup_t              lookup,
  input  logic [cu_pkg::BINOM_W-1:0]   binom
);

  localparam int BUF   = (MAX_ITEMS < cu_pkg::COLS - 1) ? MAX_ITEMS : cu_pkg::COLS - 1;
  localparam int BIDX_W = (BUF > 1) ? $clog2(BUF) : 1;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_CHECK, S_READ, S_CMP, S_EMIT, S_BAD
  } state_t;

  state_t                        state;
  logic [cu_pkg::RANK_W-1:0]     rem;
  logic [cu_pkg::COUNT_W-1:0]    cand;
  logic [cu_pkg::COUNT_W-1:0]    pos;
  logic [cu_pkg::COUNT_W-1:0]    count;
  logic [cu_pkg::COUNT_W-1:0]    emit_idx;
  logic [cu_pkg::COUNT_W-1:0]    elems [BUF];
  logic [cu_pkg::COUNT_W-1:0]    pos_m1;
  logic                          out_free;
  logic                          pick;
  logic                          emit_last;
  logic                          beat_load;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign pos_m1    = pos - cu_pkg::COUNT_W'(1);
  assign emit_last = (emit_idx == count - cu_pkg::COUNT_W'(1));
  assign beat_load = (state inside {S_EMIT, S_BAD}) && out_free;
  // take the candidate once its binomial fits, or at the bottom
  assign pick      = (cand == '0) || (binom <= {1'b0, rem});

  always_comb begin
    if (state == S_IDLE) begin
      lookup.row = req_data.total_items;
      lookup.col = req_data.chosen_count;
    end else begin
      lookup.row = cand;
      lookup.col = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CMP && pick) begin
      elems[pos_m1[BIDX_W-1:0]] <= cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      rsp_valid <= 1'b0;
    end else begin
      if (beat_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          if (table_ready) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          rem   <= req_data.rank_index;
          cand  <= req_data.total_items - cu_pkg::COUNT_W'(1);
          pos   <= req_data.chosen_count;
          count <= req_data.chosen_count;
          if (req_valid && req_data.chosen_count != '0) begin
            if (req_data.chosen_count > req_data.total_items ||
                32'(req_data.total_items) > MAX_ITEMS) begin
              state <= S_BAD;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if ({1'b0, rem} >= binom) begin
            state <= S_BAD;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          cand <= cand - cu_pkg::COUNT_W'(1);
          if (pick) begin
            rem <= rem - binom[cu_pkg::RANK_W-1:0];
            if (pos == cu_pkg::COUNT_W'(1)) begin
              emit_idx <= '0;
              state    <= S_EMIT;
            end else begin
              pos   <= pos_m1;
              state <= S_READ;
            end
          end else begin
            state <= S_READ;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            rsp_data.element <= elems[emit_idx[BIDX_W-1:0]];
            rsp_data.last    <= emit_last;
            rsp_data.invalid <= 1'b0;
            emit_idx         <= emit_idx + cu_pkg::COUNT_W'(1);
            if (emit_last) begin
              state <= S_IDLE;
            end
          end
        end
        S_BAD: begin
          if (out_free) begin
            rsp_data.element <= '0;
            rsp_data.last    <= 1'b1;
            rsp_data.invalid <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

endmodule

/* sv/cu_checker.sv */
module cu_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input cu_pkg::req_t  req_data,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input cu_pkg::rsp_t  rsp_data
);

  logic                       in_run;
  logic [cu_pkg::COUNT_W-1:0] prev_el;

  // track the last element of an unfinished response run
  always_ff @(posedge clk) begin
    if (rst) begin
      in_run <= 1'b0;
    end else if (rsp_valid && !rsp_stall) begin
      in_run  <= !rsp_data.last;
      prev_el <= rsp_data.element;
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("response beat dropped or changed while stalled");

  a_invalid_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.invalid |-> rsp_data.last && rsp_data.element == '0)
    else $error("invalid beat must be a lone last beat with zero element");

  a_ascending: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && in_run |-> rsp_data.element > prev_el && !rsp_data.invalid)
    else $error("elements of one run not strictly ascending");

  a_fill_stall: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> req_stall)
    else $error("request taken before the binomial table is built");

  a_empty_skip: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req_data.chosen_count == '0 |=> !req_stall)
    else $error("empty request must leave the input open");

endmodule

bind combination_unranker_top cu_checker u_cu_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req_data  (req_data),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_data  (rsp_data)
);
